### design/crcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcl_pkg
// Shared types, codes and the CRC-8 byte step for the register link.
// ----------------------------------------------------------------------------
package crcl_pkg;

    // Request codes on the input channel
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_RX    = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // Result codes on the output channel
    localparam logic [1:0] RK_TX   = 2'd0;
    localparam logic [1:0] RK_DONE = 2'd1;
    localparam logic [1:0] RK_FAIL = 2'd2;

    // Register indexes on the APB port
    localparam logic [1:0] REG_NODE    = 2'd0;
    localparam logic [1:0] REG_SYNC    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_RETRY   = 2'd3;

    localparam int PADDR_W = 4;

    // Register reset values
    localparam logic [7:0]  NODE_RST    = 8'd0;
    localparam logic [7:0]  SYNC_RST    = 8'd5;
    localparam logic [15:0] TIMEOUT_RST = 16'd20;
    localparam logic [3:0]  RETRY_RST   = 4'd2;

    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] REPLY_MID = 8'hFF;

    // Frame byte positions
    localparam logic [2:0] FB_SYNC    = 3'd0;
    localparam logic [2:0] FB_NODE    = 3'd1;
    localparam logic [2:0] FB_REG     = 3'd2;
    localparam logic [2:0] FB_D3      = 3'd3;
    localparam logic [2:0] FB_D2      = 3'd4;
    localparam logic [2:0] FB_D1      = 3'd5;
    localparam logic [2:0] FB_D0      = 3'd6;
    localparam logic [2:0] FB_WR_CRC  = 3'd7;
    localparam logic [2:0] FB_RD_CRC  = 3'd3;
    localparam logic [2:0] FB_SINGLE  = 3'd0;

    // Reply byte index of the CRC byte (the fifth after the sync pattern)
    localparam logic [2:0] REPLY_CRC_IDX = 3'd4;

    localparam int CMD_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  reg_addr;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  tx_byte;
        logic [31:0] read_data;
        logic        crc_error;
        logic        last;
    } result_item_t;

    typedef struct packed {
        logic [7:0]  node_address;
        logic [7:0]  sync_byte;
        logic [15:0] reply_timeout;
        logic [3:0]  retry_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_DONE  = 2'd2,
        CMD_FAIL  = 2'd3
    } cmd_kind_t;

    // Work handed from the front to the frame builder
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  sync_byte;
        logic [7:0]  node_address;
        logic [6:0]  reg_addr;
        logic [31:0] data;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_HUNT    = 3'b010,
        PH_COLLECT = 3'b100
    } phase_t;

    // One byte through the CRC, data bits LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            if (c[7] ^ data[i]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### design/crc8_uart_register_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_uart_register_link
// Host side of a single-wire register link with CRC-8 (poly 0x07, LSB first):
// builds write and read frames, hunts and checks read replies, retries.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Beat
//  s_      | in        | s_valid / s_ready       | req_item_t: request, rx byte or tick
//  m_      | out       | m_valid / m_ready       | result_item_t: tx byte or read result
//  APB     | in / out  | psel, penable / pready  | 32-bit register write or read
//
// The link state machine takes one input beat per cycle whenever the command
// queue (CMD_QUEUE_DEPTH entries) has room; the command it pushes is registered in the queue.
// The frame builder emits one result beat per cycle while the output register is free:
// a write frame is 8 beats, a read frame 4, a read result 1; its single byte lane sets the rate.
// A stalled m_ready backs up the output register, then the queue, then s_ready.
// Reset is synchronous, active low, and takes effect at once: no clearing pass.
// ----------------------------------------------------------------------------
module crc8_uart_register_link
    import crcl_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  req_item_t          s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output result_item_t       m_payload
);

    cfg_t cfg;
    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_head;

    crcl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crcl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    crcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    crcl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

### design/crcl_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcl_regs
// APB register file: node address, sync byte, reply timeout, retry limit.
// ----------------------------------------------------------------------------
module crcl_regs
    import crcl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Write on the access beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_address  <= NODE_RST;
            cfg_reg.sync_byte     <= SYNC_RST;
            cfg_reg.reply_timeout <= TIMEOUT_RST;
            cfg_reg.retry_limit   <= RETRY_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_NODE:    cfg_reg.node_address  <= pwdata[7:0];
                REG_SYNC:    cfg_reg.sync_byte     <= pwdata[7:0];
                REG_TIMEOUT: cfg_reg.reply_timeout <= pwdata[15:0];
                REG_RETRY:   cfg_reg.retry_limit   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (paddr[3:2])
            REG_NODE:    prdata = {24'd0, cfg_reg.node_address};
            REG_SYNC:    prdata = {24'd0, cfg_reg.sync_byte};
            REG_TIMEOUT: prdata = {16'd0, cfg_reg.reply_timeout};
            REG_RETRY:   prdata = {28'd0, cfg_reg.retry_limit};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

### design/crcl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcl_front
// Link state machine: classifies each beat, hunts and checks replies, counts
// ticks and attempts, and hands at most one command per beat to the queue.
// ----------------------------------------------------------------------------
module crcl_front
    import crcl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  req_item_t s_payload,
    input  logic      q_full,
    output logic      q_push,
    output cmd_t      q_cmd
);

    phase_t      phase_reg, phase_next;
    logic [23:0] window_reg, window_next;
    logic [31:0] data_shift_reg, data_shift_next;
    logic [2:0]  count_reg, count_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [3:0]  attempts_reg, attempts_next;
    logic [6:0]  pending_reg, pending_next;
    logic [7:0]  crc_acc_reg, crc_acc_next;
    logic [7:0]  lag_reg, lag_next;

    logic        accept;
    logic        busy;
    logic        fail;
    logic        start;
    logic [15:0] timeout_eff;
    logic [3:0]  retry_eff;
    logic [23:0] shifted;
    logic [23:0] target;
    logic [7:0]  crc_calc;

    assign s_ready     = !q_full;
    assign accept      = s_valid && s_ready;
    assign busy        = (phase_reg != PH_IDLE);
    assign timeout_eff = (cfg.reply_timeout == 16'd0) ? 16'd1 : cfg.reply_timeout;
    assign retry_eff   = (cfg.retry_limit == 4'd0) ? 4'd1 : cfg.retry_limit;
    assign shifted     = {window_reg[15:0], s_payload.rx_byte};
    assign target      = {cfg.sync_byte, REPLY_MID, 1'b0, pending_reg};
    assign crc_calc    = crc8_byte(crc_acc_reg, lag_reg);

    // Classify the beat and work out the next link state
    always_comb begin
        phase_next      = phase_reg;
        window_next     = window_reg;
        data_shift_next = data_shift_reg;
        count_next      = count_reg;
        ticks_next      = ticks_reg;
        attempts_next   = attempts_reg;
        pending_next    = pending_reg;
        crc_acc_next    = crc_acc_reg;
        lag_next        = lag_reg;
        q_push          = 1'b0;
        q_cmd           = '0;
        fail            = 1'b0;
        start           = 1'b0;

        if (accept) begin
            unique case (s_payload.req_type)
                REQ_WRITE: begin
                    if (!busy) begin
                        q_push             = 1'b1;
                        q_cmd.kind         = CMD_WRITE;
                        q_cmd.sync_byte    = cfg.sync_byte;
                        q_cmd.node_address = cfg.node_address;
                        q_cmd.reg_addr     = s_payload.reg_addr;
                        q_cmd.data         = s_payload.write_data;
                    end
                end
                REQ_READ: begin
                    if (!busy) begin
                        pending_next  = s_payload.reg_addr;
                        attempts_next = retry_eff;
                        start         = 1'b1;
                    end
                end
                REQ_RX: begin
                    if (phase_reg == PH_HUNT) begin
                        window_next = shifted;
                        if (shifted == target) begin
                            phase_next   = PH_COLLECT;
                            count_next   = 3'd0;
                            ticks_next   = timeout_eff;
                            // Header CRC; the register byte trails one beat
                            crc_acc_next = crc8_byte(crc8_byte(8'h00, cfg.sync_byte),
                                                     REPLY_MID);
                            lag_next     = {1'b0, pending_reg};
                        end
                    end else if (phase_reg == PH_COLLECT) begin
                        data_shift_next = {data_shift_reg[23:0], s_payload.rx_byte};
                        count_next      = count_reg + 3'd1;
                        if (count_reg == REPLY_CRC_IDX) begin
                            if (crc_calc != s_payload.rx_byte || crc_calc == 8'h00) begin
                                fail = 1'b1;
                            end else begin
                                phase_next    = PH_IDLE;
                                attempts_next = 4'd0;
                                q_push        = 1'b1;
                                q_cmd.kind    = CMD_DONE;
                                q_cmd.data    = data_shift_reg;
                            end
                        end else begin
                            crc_acc_next = crc_calc;
                            lag_next     = s_payload.rx_byte;
                        end
                    end
                end
                REQ_TICK: begin
                    if (busy) begin
                        ticks_next = ticks_reg - 16'd1;
                        if (ticks_next == 16'd0) begin
                            fail = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Retry or give up
        if (fail) begin
            if (attempts_reg > 4'd1) begin
                attempts_next = attempts_reg - 4'd1;
                start         = 1'b1;
            end else begin
                attempts_next = 4'd0;
                phase_next    = PH_IDLE;
                q_push        = 1'b1;
                q_cmd.kind    = CMD_FAIL;
            end
        end

        // Send the read frame and open a new hunt
        if (start) begin
            q_push             = 1'b1;
            q_cmd.kind         = CMD_READ;
            q_cmd.sync_byte    = cfg.sync_byte;
            q_cmd.node_address = cfg.node_address;
            q_cmd.reg_addr     = pending_next;
            q_cmd.data         = 32'd0;
            window_next        = 24'd0;
            data_shift_next    = 32'd0;
            count_next         = 3'd0;
            ticks_next         = timeout_eff;
            phase_next         = PH_HUNT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            window_reg     <= 24'd0;
            data_shift_reg <= 32'd0;
            count_reg      <= 3'd0;
            ticks_reg      <= 16'd0;
            attempts_reg   <= 4'd0;
            pending_reg    <= 7'd0;
            crc_acc_reg    <= 8'd0;
            lag_reg        <= 8'd0;
        end else begin
            phase_reg      <= phase_next;
            window_reg     <= window_next;
            data_shift_reg <= data_shift_next;
            count_reg      <= count_next;
            ticks_reg      <= ticks_next;
            attempts_reg   <= attempts_next;
            pending_reg    <= pending_next;
            crc_acc_reg    <= crc_acc_next;
            lag_reg        <= lag_next;
        end
    end

endmodule

### design/crcl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcl_queue
// Short command queue between the link state machine and the frame builder.
// ----------------------------------------------------------------------------
module crcl_queue
    import crcl_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("command popped from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue fill count beyond depth");

endmodule

### design/crcl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcl_back
// Frame builder: turns each command into result beats, one a cycle unless m_ready
// stalls, with a running CRC over transmitted frame bytes, into an output register.
// ----------------------------------------------------------------------------
module crcl_back
    import crcl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    input  cmd_t         q_head,
    output logic         q_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output result_item_t m_payload
);

    logic         busy_reg;
    cmd_t         cmd_reg;
    logic [2:0]   idx_reg;
    logic [7:0]   crc_reg;
    logic         m_valid_reg;
    result_item_t m_payload_reg;

    logic         out_free;
    logic         fire;
    cmd_t         cur_cmd;
    logic [2:0]   cur_idx;
    logic [7:0]   crc_base;
    logic [2:0]   last_idx;
    logic         beat_last;
    logic [7:0]   frame_byte;
    result_item_t beat;

    assign out_free = !m_valid_reg || m_ready;
    assign cur_cmd  = busy_reg ? cmd_reg : q_head;
    assign cur_idx  = busy_reg ? idx_reg : FB_SYNC;
    assign crc_base = busy_reg ? crc_reg : 8'h00;
    assign fire     = (busy_reg || q_valid) && out_free;
    assign q_pop    = !busy_reg && q_valid && out_free;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Pick the frame byte for this beat
    always_comb begin
        unique case (cur_cmd.kind)
            CMD_WRITE: last_idx = FB_WR_CRC;
            CMD_READ:  last_idx = FB_RD_CRC;
            default:   last_idx = FB_SINGLE;
        endcase
        beat_last = (cur_idx == last_idx);

        if (cur_cmd.kind == CMD_WRITE) begin
            unique case (cur_idx)
                FB_SYNC:   frame_byte = cur_cmd.sync_byte;
                FB_NODE:   frame_byte = cur_cmd.node_address;
                FB_REG:    frame_byte = {1'b1, cur_cmd.reg_addr};
                FB_D3:     frame_byte = cur_cmd.data[31:24];
                FB_D2:     frame_byte = cur_cmd.data[23:16];
                FB_D1:     frame_byte = cur_cmd.data[15:8];
                FB_D0:     frame_byte = cur_cmd.data[7:0];
                default:   frame_byte = crc_base;
            endcase
        end else begin
            unique case (cur_idx)
                FB_SYNC:   frame_byte = cur_cmd.sync_byte;
                FB_NODE:   frame_byte = cur_cmd.node_address;
                FB_REG:    frame_byte = {1'b0, cur_cmd.reg_addr};
                default:   frame_byte = crc_base;
            endcase
        end
    end

    // Build the result beat
    always_comb begin
        beat      = '0;
        beat.last = beat_last;
        unique case (cur_cmd.kind)
            CMD_WRITE, CMD_READ: begin
                beat.result_kind = RK_TX;
                beat.tx_byte     = frame_byte;
            end
            CMD_DONE: begin
                beat.result_kind = RK_DONE;
                beat.read_data   = cur_cmd.data;
            end
            default: begin
                beat.result_kind = RK_FAIL;
                beat.crc_error   = 1'b1;
            end
        endcase
    end

    // Hold the command being framed
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_head;
        end
        if (fire) begin
            crc_reg <= crc8_byte(crc_base, frame_byte);
            idx_reg <= cur_idx + 3'd1;
        end
    end

    // Advance the framer and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            busy_reg    <= !beat_last;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_payload_reg <= beat;
        end
    end

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && beat_last |=> !busy_reg)
        else $error("framer still busy after the closing beat");

    a_busy_frames_only: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cmd_reg.kind == CMD_WRITE || cmd_reg.kind == CMD_READ))
        else $error("single-beat command parked in the framer");

    a_idx_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg != FB_SYNC) &&
                     (cmd_reg.kind == CMD_WRITE || idx_reg <= FB_RD_CRC))
        else $error("frame byte index outside the frame");

endmodule
